### rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

### rtl/core/mpsps_pkg.sv
`timescale 1ns / 1ps

package mpsps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DISC_CENTRE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_CENTRE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOON_PHASE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_ROW        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SKY_HIGH_COLOUR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SKY_LOW_COLOUR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_COLOUR     = 3'd7;

    localparam logic [2:0] PHASE_NEW           = 3'd0;
    localparam logic [2:0] PHASE_WAX_CRESCENT  = 3'd1;
    localparam logic [2:0] PHASE_FIRST_Q       = 3'd2;
    localparam logic [2:0] PHASE_WAX_GIBBOUS   = 3'd3;
    localparam logic [2:0] PHASE_FULL          = 3'd4;
    localparam logic [2:0] PHASE_WANE_GIBBOUS  = 3'd5;
    localparam logic [2:0] PHASE_LAST_Q        = 3'd6;
    localparam logic [2:0] PHASE_WANE_CRESCENT = 3'd7;

    localparam logic [1:0] REGION_SKY    = 2'd0;
    localparam logic [1:0] REGION_LIT    = 2'd1;
    localparam logic [1:0] REGION_SHADOW = 2'd2;

    typedef struct packed {
        logic [7:0] disc_centre_x;
        logic [7:0] disc_centre_y;
        logic [2:0] moon_phase;
        logic [7:0] band_row;
        logic [7:0] blend_height;
        logic [7:0] sky_high_colour;
        logic [7:0] sky_low_colour;
        logic [7:0] disc_colour;
    } cfg_t;

    typedef struct packed {
        logic in_disc;
        logic in_shadow;
    } disc_hit_t;

endpackage

### rtl/core/mpsps_cfg_regs.sv
`timescale 1ns / 1ps

module mpsps_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mpsps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpsps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output mpsps_pkg::cfg_t                  cfg
);
    import mpsps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISC_CENTRE_X:   cfg_next.disc_centre_x   = cfg_wdata;
                CFG_DISC_CENTRE_Y:   cfg_next.disc_centre_y   = cfg_wdata;
                CFG_MOON_PHASE:      cfg_next.moon_phase      = cfg_wdata[2:0];
                CFG_BAND_ROW:        cfg_next.band_row        = cfg_wdata;
                CFG_BLEND_HEIGHT:    cfg_next.blend_height    = cfg_wdata;
                CFG_SKY_HIGH_COLOUR: cfg_next.sky_high_colour = cfg_wdata;
                CFG_SKY_LOW_COLOUR:  cfg_next.sky_low_colour  = cfg_wdata;
                CFG_DISC_COLOUR:     cfg_next.disc_colour     = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disc_centre_x   <= 8'd72;
            cfg_reg.disc_centre_y   <= 8'd60;
            cfg_reg.moon_phase      <= 3'd4;
            cfg_reg.band_row        <= 8'd80;
            cfg_reg.blend_height    <= 8'd16;
            cfg_reg.sky_high_colour <= 8'd0;
            cfg_reg.sky_low_colour  <= 8'd0;
            cfg_reg.disc_colour     <= 8'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/mpsps_sky.sv
`timescale 1ns / 1ps

module mpsps_sky (
    input  logic            clk,
    input  logic [7:0]      pixel_x,
    input  logic [7:0]      pixel_y,
    input  mpsps_pkg::cfg_t cfg,
    output logic [7:0]      sky_colour
);
    import mpsps_pkg::*;

    typedef enum logic [1:0] {
        SKY_HIGH,
        SKY_LOW,
        SKY_BAND
    } sky_sel_t;

    logic [8:0] band_end;
    logic [7:0] off_next;
    logic [2:0] dither;
    sky_sel_t   sel_next;

    sky_sel_t   sel_reg;
    logic [7:0] off_reg;
    logic [3:0] m1_reg;

    logic [11:0] prod;
    logic [11:0] off8;
    logic        lower;
    logic [7:0]  colour_next;
    logic [7:0]  colour_reg;

    // stage A: band classification and dither cell
    always_comb
    begin
        band_end = {1'b0, cfg.band_row} + {1'b0, cfg.blend_height};
        off_next = pixel_y - cfg.band_row;
        // (x + 3 * off) mod 8
        dither   = pixel_x[2:0] + off_next[2:0] + {off_next[1:0], 1'b0};
        if (pixel_y < cfg.band_row)
            sel_next = SKY_HIGH;
        else if ({1'b0, pixel_y} >= band_end || cfg.blend_height == 8'd0)
            sel_next = SKY_LOW;
        else
            sel_next = SKY_BAND;
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        off_reg <= off_next;
        m1_reg  <= {1'b0, dither} + 4'd1;
    end

    // stage B: cell < (off*8)/h  <=>  (cell+1)*h <= off*8
    always_comb
    begin
        prod  = {8'd0, m1_reg} * {4'd0, cfg.blend_height};
        off8  = {1'b0, off_reg, 3'b000};
        lower = (prod <= off8);
        case (sel_reg)
            SKY_HIGH: colour_next = cfg.sky_high_colour;
            SKY_LOW:  colour_next = cfg.sky_low_colour;
            SKY_BAND: colour_next = lower ? cfg.sky_low_colour : cfg.sky_high_colour;
            default:  colour_next = cfg.sky_high_colour;
        endcase
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
    end

    assign sky_colour = colour_reg;

endmodule

### rtl/core/mpsps_disc.sv
`timescale 1ns / 1ps

module mpsps_disc #(
    parameter int DISC_RADIUS = 12
) (
    input  logic                 clk,
    input  logic [7:0]           pixel_x,
    input  logic [7:0]           pixel_y,
    input  mpsps_pkg::cfg_t      cfg,
    output mpsps_pkg::disc_hit_t hit
);
    import mpsps_pkg::*;

    localparam logic signed [9:0] OFS_NEAR = 10'((DISC_RADIUS * 6) / 10);
    localparam logic signed [9:0] OFS_FAR  = 10'((DISC_RADIUS * 14) / 10);
    localparam logic [17:0]       R_SQ     = 18'(DISC_RADIUS * DISC_RADIUS);

    logic signed [8:0] dx_next;
    logic signed [8:0] dy_next;
    logic signed [9:0] dx2_next;
    logic              shade_fixed_next;

    logic signed [8:0] dx_reg;
    logic signed [8:0] dy_reg;
    logic signed [9:0] dx2_reg;
    logic              shade_fixed_reg;
    logic              use_circle_reg;

    logic signed [17:0] dx_sq_full;
    logic signed [17:0] dy_sq_full;
    logic signed [19:0] dx2_sq_full;

    logic [15:0] dx_sq_reg;
    logic [15:0] dy_sq_reg;
    logic [16:0] dx2_sq_reg;
    logic        shade_fixed_b_reg;
    logic        use_circle_b_reg;

    logic [17:0] dist_main;
    logic [17:0] dist_shade;

    // stage A: offsets from the disc centre and from the shadow centre
    always_comb
    begin
        dx_next = $signed({1'b0, pixel_x}) - $signed({1'b0, cfg.disc_centre_x});
        dy_next = $signed({1'b0, pixel_y}) - $signed({1'b0, cfg.disc_centre_y});
        case (cfg.moon_phase)
            PHASE_WAX_CRESCENT:  dx2_next = 10'(dx_next) + OFS_NEAR;
            PHASE_WAX_GIBBOUS:   dx2_next = 10'(dx_next) + OFS_FAR;
            PHASE_WANE_GIBBOUS:  dx2_next = 10'(dx_next) - OFS_FAR;
            PHASE_WANE_CRESCENT: dx2_next = 10'(dx_next) - OFS_NEAR;
            default:             dx2_next = 10'(dx_next);
        endcase
        case (cfg.moon_phase)
            PHASE_NEW:     shade_fixed_next = 1'b1;
            PHASE_FIRST_Q: shade_fixed_next = dx_next[8];
            PHASE_LAST_Q:  shade_fixed_next = !dx_next[8] && (dx_next != 9'sd0);
            default:       shade_fixed_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        dx2_reg         <= dx2_next;
        shade_fixed_reg <= shade_fixed_next;
        use_circle_reg  <= cfg.moon_phase[0];
    end

    // stage B: squares
    always_comb
    begin
        dx_sq_full  = dx_reg * dx_reg;
        dy_sq_full  = dy_reg * dy_reg;
        dx2_sq_full = dx2_reg * dx2_reg;
    end

    always_ff @(posedge clk)
    begin
        dx_sq_reg         <= dx_sq_full[15:0];
        dy_sq_reg         <= dy_sq_full[15:0];
        dx2_sq_reg        <= dx2_sq_full[16:0];
        shade_fixed_b_reg <= shade_fixed_reg;
        use_circle_b_reg  <= use_circle_reg;
    end

    always_comb
    begin
        dist_main     = {2'b00, dx_sq_reg} + {2'b00, dy_sq_reg};
        dist_shade    = {1'b0, dx2_sq_reg} + {2'b00, dy_sq_reg};
        hit.in_disc   = (dist_main <= R_SQ);
        hit.in_shadow = shade_fixed_b_reg || (use_circle_b_reg && (dist_shade <= R_SQ));
    end

endmodule

### rtl/core/moon_phase_sky_pixel_shader_top.sv
`timescale 1ns / 1ps
// channel   handshake          payload
// --------  -----------------  ---------------------------------
// pixel in  start, busy        pixel_x, pixel_y
// result    done (strobe)      pixel_colour, region
// config    cfg_we             cfg_index, cfg_wdata
//
// One pixel per clock; a beat taken passes stages A and B (squarer and
// dither-multiply) and output registers, then is shown for a single cycle.
// busy is held low: the pipeline never stalls and the receiver cannot stall.
// Reset clears the stage valid bits and loads the register reset values.
// User must write configuration only while no beat is in flight; unenforced.

module moon_phase_sky_pixel_shader_top #(
    parameter int DISC_RADIUS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       pixel_x,
    input  logic [7:0]                       pixel_y,
    output logic                             done,
    output logic [7:0]                       pixel_colour,
    output logic [1:0]                       region,
    input  logic                             cfg_we,
    input  logic [mpsps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpsps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mpsps_pkg::*;

    cfg_t      cfg;
    disc_hit_t hit;
    logic [7:0] sky_colour;

    logic       accept;
    logic       va_reg;
    logic       vb_reg;
    logic       done_reg;
    logic [7:0] colour_next;
    logic [1:0] region_next;
    logic [7:0] colour_reg;
    logic [1:0] region_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    mpsps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mpsps_sky u_sky (
        .clk        (clk),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .cfg        (cfg),
        .sky_colour (sky_colour)
    );

    mpsps_disc #(
        .DISC_RADIUS (DISC_RADIUS)
    ) u_disc (
        .clk     (clk),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .cfg     (cfg),
        .hit     (hit)
    );

    always_comb
    begin
        if (!hit.in_disc)
        begin
            colour_next = sky_colour;
            region_next = REGION_SKY;
        end
        else if (hit.in_shadow)
        begin
            colour_next = sky_colour;
            region_next = REGION_SHADOW;
        end
        else
        begin
            colour_next = cfg.disc_colour;
            region_next = REGION_LIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= accept;
            vb_reg   <= va_reg;
            done_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
        region_reg <= region_next;
    end

    assign done         = done_reg;
    assign pixel_colour = colour_reg;
    assign region       = region_reg;

endmodule

### rtl/core/mpsps_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpsps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] region
);
    import mpsps_pkg::*;

    // every beat taken comes out on done through the va, vb and done registers
    `ASSERT_PROP(a_beat_latency, clk, rst_n, (start && !busy) |-> ##3 done)
    // no result without a matching beat taken before it
    `ASSERT_PROP(a_no_spurious, clk, rst_n, done |-> $past(start && !busy, 3))
    // the pipeline never back-pressures
    `ASSERT_NEVER(a_never_busy, clk, rst_n, busy)
    // region code on a result is one of the three defined codes
    `ASSERT_PROP(a_region_code, clk, rst_n, done |-> (region <= REGION_SHADOW))

endmodule

bind moon_phase_sky_pixel_shader_top mpsps_checker u_mpsps_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .region (region)
);
